FILE: src/egm3_pkg.sv
// Shared constants and types of the 3x3 edge gradient magnitude block.
package egm3_pkg;

  localparam int PIXEL_BITS = 8;
  localparam int CW_W       = 2;
  localparam int GRAD_W     = PIXEL_BITS + 3;
  localparam int SQ_W       = 2 * GRAD_W;
  localparam int ROOT_W     = GRAD_W + 1;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int REM_W      = ROOT_W + 2;
  localparam int MAG_W      = 11;

  localparam logic [CW_W-1:0]  CW_RESET = CW_W'(2);
  localparam logic [MAG_W-1:0] MAG_MAX  = {MAG_W{1'b1}};

  typedef logic [PIXEL_BITS-1:0] pix_t;
  typedef logic [GRAD_W-1:0]     grad_t;
  typedef logic [CW_W-1:0]       cw_t;
  typedef logic [MAG_W-1:0]      mag_t;

  typedef struct packed {
    pix_t above_left;
    pix_t above_mid;
    pix_t above_right;
    pix_t mid_left;
    pix_t mid_right;
    pix_t below_left;
    pix_t below_mid;
    pix_t below_right;
  } win_t;

  typedef struct packed {
    logic              vld;
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_word_t;

endpackage

FILE: src/egm3_ifs.sv
// Handshake channel interfaces for window, magnitude and weight words.
interface egm3_in_if;
  logic            valid;
  logic            ready;
  egm3_pkg::pix_t  above_left;
  egm3_pkg::pix_t  above_mid;
  egm3_pkg::pix_t  above_right;
  egm3_pkg::pix_t  mid_left;
  egm3_pkg::pix_t  mid_right;
  egm3_pkg::pix_t  below_left;
  egm3_pkg::pix_t  below_mid;
  egm3_pkg::pix_t  below_right;
  modport source (output valid, above_left, above_mid, above_right, mid_left, mid_right,
                  below_left, below_mid, below_right, input ready);
  modport sink (input valid, above_left, above_mid, above_right, mid_left, mid_right,
                below_left, below_mid, below_right, output ready);
endinterface

interface egm3_out_if;
  logic            valid;
  logic            ready;
  egm3_pkg::mag_t  magnitude;
  modport source (output valid, magnitude, input ready);
  modport sink (input valid, magnitude, output ready);
endinterface

interface egm3_cfg_if;
  logic            valid;
  logic            ready;
  egm3_pkg::cw_t   center_weight;
  modport source (output valid, center_weight, input ready);
  modport sink (input valid, center_weight, output ready);
endinterface

FILE: src/edge_gradient_magnitude_3x3_top.sv
// Top level of the 3x3 Sobel/Prewitt edge gradient magnitude block.
//
// The in_ch channel takes one word per cycle while in_ch.ready is high: the
// eight neighbours of a 3x3 window, the centre pixel excluded. The out_ch
// channel gives one magnitude word per input word, in order: the floor of
// the square root of the summed squared row and column gradients, saturated
// to 11 bits. The cfg_ch channel writes the centre weight (1 Prewitt, 2 Sobel)
// and is always ready; it should only be written while the block is idle.
// The word passes 17 register stages, the first loaded at the accepting
// edge: four of gradient and square arithmetic, one per root bit in a chain
// of 12 square root cells, and one output register. Throughput is one word
// per cycle while in_ch.ready is high. Reset clears all valid flags and sets
// the centre weight to 2. When the receiver stalls, a skid register catches
// the word in flight and the whole pipeline then holds; in_ch.ready falls
// only while the skid register is occupied.
module edge_gradient_magnitude_3x3_top (
  input  logic       clk,
  input  logic       rst_n,
  egm3_in_if.sink    in_ch,
  egm3_out_if.source out_ch,
  egm3_cfg_if.sink   cfg_ch
);

  localparam int RTW = egm3_pkg::ROOT_W;

  egm3_pkg::cw_t        weight_r, weight_nxt;
  egm3_pkg::win_t       win;
  egm3_pkg::sqrt_word_t chain [RTW+1];
  logic                 en;

  always_comb begin
    weight_nxt = weight_r;
    if (cfg_ch.valid) begin
      weight_nxt = cfg_ch.center_weight;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= egm3_pkg::CW_RESET;
    end else begin
      weight_r <= weight_nxt;
    end
  end

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = en;

  assign win.above_left  = in_ch.above_left;
  assign win.above_mid   = in_ch.above_mid;
  assign win.above_right = in_ch.above_right;
  assign win.mid_left    = in_ch.mid_left;
  assign win.mid_right   = in_ch.mid_right;
  assign win.below_left  = in_ch.below_left;
  assign win.below_mid   = in_ch.below_mid;
  assign win.below_right = in_ch.below_right;

  egm3_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_ch.valid),
    .win     (win),
    .weight  (weight_r),
    .rad_out (chain[0])
  );

  for (genvar i = 0; i < RTW; i++) begin : g_cell
    egm3_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .prev  (chain[i]),
      .next  (chain[i+1])
    );
  end

  egm3_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (chain[RTW]),
    .out_ready (out_ch.ready),
    .out_vld   (out_ch.valid),
    .out_mag   (out_ch.magnitude),
    .en        (en)
  );

  a_weight_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> (weight_r == egm3_pkg::CW_RESET))
    else $error("centre weight not at its reset value after reset");

endmodule

FILE: src/egm3_front.sv
// Weighted row and column sums, gradients, squares and their sum.
module egm3_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_vld,
  input  egm3_pkg::win_t         win,
  input  egm3_pkg::cw_t          weight,
  output egm3_pkg::sqrt_word_t   rad_out
);

  localparam int GW = egm3_pkg::GRAD_W;
  localparam int SW = egm3_pkg::SQ_W;
  localparam int RW = egm3_pkg::RAD_W;

  logic          s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  logic [GW-1:0] top_r, bot_r, rgt_r, lft_r;
  logic [GW-1:0] gr_r, gc_r;
  logic [SW-1:0] sqr_r, sqc_r;
  logic [RW-1:0] rad_r;

  logic [GW-1:0] top_nxt, bot_nxt, rgt_nxt, lft_nxt;
  logic [GW-1:0] gr_nxt, gc_nxt;
  logic [SW-1:0] sqr_nxt, sqc_nxt;
  logic [RW-1:0] rad_nxt;

  always_comb begin
    top_nxt = GW'(win.above_left) + GW'(win.above_mid) * GW'(weight) + GW'(win.above_right);
    bot_nxt = GW'(win.below_left) + GW'(win.below_mid) * GW'(weight) + GW'(win.below_right);
    rgt_nxt = GW'(win.above_right) + GW'(win.mid_right) * GW'(weight) + GW'(win.below_right);
    lft_nxt = GW'(win.above_left) + GW'(win.mid_left) * GW'(weight) + GW'(win.below_left);
    gr_nxt  = (top_r >= bot_r) ? (top_r - bot_r) : (bot_r - top_r);
    gc_nxt  = (rgt_r >= lft_r) ? (rgt_r - lft_r) : (lft_r - rgt_r);
    sqr_nxt = SW'(gr_r) * SW'(gr_r);
    sqc_nxt = SW'(gc_r) * SW'(gc_r);
    rad_nxt = RW'(sqr_r) + RW'(sqc_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      top_r <= top_nxt;
      bot_r <= bot_nxt;
      rgt_r <= rgt_nxt;
      lft_r <= lft_nxt;
      gr_r  <= gr_nxt;
      gc_r  <= gc_nxt;
      sqr_r <= sqr_nxt;
      sqc_r <= sqc_nxt;
      rad_r <= rad_nxt;
    end
  end

  assign rad_out.vld  = s4_vld_r;
  assign rad_out.rad  = rad_r;
  assign rad_out.rem  = '0;
  assign rad_out.root = '0;

endmodule

FILE: src/egm3_sqrt_cell.sv
// One digit step of the square root chain: takes two radicand bits, yields one root bit.
module egm3_sqrt_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  egm3_pkg::sqrt_word_t prev,
  output egm3_pkg::sqrt_word_t next
);

  localparam int RTW = egm3_pkg::ROOT_W;
  localparam int RMW = egm3_pkg::REM_W;
  localparam int RDW = egm3_pkg::RAD_W;

  logic           vld_r;
  logic [RDW-1:0] rad_r, rad_nxt;
  logic [RMW-1:0] rem_r, rem_nxt;
  logic [RTW-1:0] root_r, root_nxt;
  logic [RMW-1:0] rem_sh, trial;

  always_comb begin
    rem_sh  = {prev.rem[RMW-3:0], prev.rad[RDW-1:RDW-2]};
    trial   = {prev.root, 2'b01};
    rad_nxt = {prev.rad[RDW-3:0], 2'b00};
    if (rem_sh >= trial) begin
      rem_nxt  = rem_sh - trial;
      root_nxt = {prev.root[RTW-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh;
      root_nxt = {prev.root[RTW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= prev.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign next.vld  = vld_r;
  assign next.rad  = rad_r;
  assign next.rem  = rem_r;
  assign next.root = root_r;

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> (rem_r <= {root_r, 1'b0}))
    else $error("square root remainder exceeds twice the partial root");

endmodule

FILE: src/egm3_out_buf.sv
// Output register with skid word; saturates the root to the magnitude width.
module egm3_out_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  egm3_pkg::sqrt_word_t res,
  input  logic                 out_ready,
  output logic                 out_vld,
  output egm3_pkg::mag_t       out_mag,
  output logic                 en
);

  localparam int RTW = egm3_pkg::ROOT_W;
  localparam int MW  = egm3_pkg::MAG_W;

  logic           out_vld_r, out_vld_nxt;
  logic           skid_vld_r, skid_vld_nxt;
  logic [MW-1:0]  out_mag_r, out_mag_nxt;
  logic [MW-1:0]  skid_mag_r, skid_mag_nxt;
  logic [MW-1:0]  sat_mag;
  logic           take;

  always_comb begin
    sat_mag      = (|res.root[RTW-1:MW]) ? egm3_pkg::MAG_MAX : res.root[MW-1:0];
    take         = out_vld_r && out_ready;
    out_vld_nxt  = out_vld_r;
    out_mag_nxt  = out_mag_r;
    skid_vld_nxt = skid_vld_r;
    skid_mag_nxt = skid_mag_r;
    if (skid_vld_r) begin
      if (take) begin
        out_mag_nxt  = skid_mag_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (res.vld) begin
      if (!out_vld_r || take) begin
        out_vld_nxt = 1'b1;
        out_mag_nxt = sat_mag;
      end else begin
        skid_vld_nxt = 1'b1;
        skid_mag_nxt = sat_mag;
      end
    end else if (take) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_mag_r  <= out_mag_nxt;
    skid_mag_r <= skid_mag_nxt;
  end

  assign out_vld = out_vld_r;
  assign out_mag = out_mag_r;
  assign en      = !skid_vld_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid word held while output register is empty");

  a_skid_catch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ready && !skid_vld_r && res.vld) |=> skid_vld_r)
    else $error("word arriving at a stalled output was not caught by the skid register");

endmodule
